/* rtl/psc_pkg.sv */
package psc_pkg;

    localparam int PSC_VALUE_W  = 64;
    localparam int PSC_TERM_W   = 32;
    localparam int PSC_REM_W    = 32;
    localparam int PSC_DIV_BITS = 4;

    localparam logic [PSC_VALUE_W-1:0] PSC_ALL_ONES = '1;

    typedef enum logic {
        PSC_FUNC_NUM_OVER_DEN = 1'b0,
        PSC_FUNC_DEN_OVER_NUM = 1'b1
    } t_func;

    // item as it travels through the long division
    typedef struct packed {
        logic                   bypass;
        logic                   sat;
        logic [PSC_TERM_W-1:0]  divisor;
        logic [PSC_REM_W-1:0]   rem;
        logic [PSC_VALUE_W-1:0] quo;
    } t_div_item;

endpackage

/* rtl/psc_if.sv */
interface psc_in_if;
    logic                            valid;
    logic                            ready;
    logic                            func;
    logic [psc_pkg::PSC_VALUE_W-1:0] value;
    logic [psc_pkg::PSC_TERM_W-1:0]  prob_numerator;
    logic [psc_pkg::PSC_TERM_W-1:0]  prob_denominator;

    modport source (output valid, func, value, prob_numerator, prob_denominator, input ready);
    modport sink   (input valid, func, value, prob_numerator, prob_denominator, output ready);
endinterface

interface psc_out_if;
    logic                            valid;
    logic                            ready;
    logic [psc_pkg::PSC_VALUE_W-1:0] scaled;
    logic                            saturated;

    modport source (output valid, scaled, saturated, input ready);
    modport sink   (input valid, scaled, saturated, output ready);
endinterface

/* rtl/psc_front.sv */
module psc_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [2:0]                      i_en,
    input  logic                            i_valid,
    input  logic                            i_func,
    input  logic [psc_pkg::PSC_VALUE_W-1:0] i_value,
    input  logic [psc_pkg::PSC_TERM_W-1:0]  i_num,
    input  logic [psc_pkg::PSC_TERM_W-1:0]  i_den,
    output logic [2:0]                      o_valid,
    output psc_pkg::t_div_item              o_item
);

    localparam int VW = psc_pkg::PSC_VALUE_W;
    localparam int TW = psc_pkg::PSC_TERM_W;
    localparam int PW = VW + TW;

    logic [2:0] r_valid;

    // stage 0: operand selection and special cases
    logic [VW-1:0] r0_value;
    logic [TW-1:0] r0_mul;
    logic [TW-1:0] r0_div;
    logic          r0_bypass;
    logic          r0_sat;

    // stage 1: partial products
    logic [2*TW-1:0] r1_hi;
    logic [2*TW-1:0] r1_lo;
    logic [TW-1:0]   r1_div;
    logic            r1_bypass;
    logic            r1_sat;
    logic [VW-1:0]   r1_byp_val;

    psc_pkg::t_div_item r2_item;

    logic          n_pass;
    logic          n_zero_div;
    logic [TW-1:0] n_mul;
    logic [TW-1:0] n_div;
    logic [PW-1:0] n_prod;
    logic          n_ovf;

    always_comb begin
        if (psc_pkg::t_func'(i_func) == psc_pkg::PSC_FUNC_DEN_OVER_NUM) begin
            n_mul = i_den;
            n_div = i_num;
        end else begin
            n_mul = i_num;
            n_div = i_den;
        end
        n_pass     = (i_value == '0) || (i_num == i_den);
        n_zero_div = !n_pass && (n_div == '0);
    end

    always_comb begin
        n_prod = {r1_hi, {TW{1'b0}}} + {{TW{1'b0}}, r1_lo};
        n_ovf  = n_prod[PW-1:VW] >= r1_div;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (i_en[0]) begin
                r_valid[0] <= i_valid;
            end
            for (int k = 1; k < 3; k++) begin
                if (i_en[k]) begin
                    r_valid[k] <= r_valid[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0] && i_valid) begin
            r0_value  <= i_value;
            r0_mul    <= n_mul;
            r0_div    <= n_div;
            r0_bypass <= n_pass || n_zero_div;
            r0_sat    <= n_zero_div;
        end
        if (i_en[1] && r_valid[0]) begin
            r1_hi      <= r0_value[VW-1:TW] * r0_mul;
            r1_lo      <= r0_value[TW-1:0] * r0_mul;
            r1_div     <= r0_div;
            r1_bypass  <= r0_bypass;
            r1_sat     <= r0_sat;
            r1_byp_val <= r0_sat ? psc_pkg::PSC_ALL_ONES : r0_value;
        end
        if (i_en[2] && r_valid[1]) begin
            r2_item.divisor <= r1_div;
            r2_item.rem     <= n_prod[PW-1:VW];
            if (r1_bypass) begin
                r2_item.bypass <= 1'b1;
                r2_item.sat    <= r1_sat;
                r2_item.quo    <= r1_byp_val;
            end else if (n_ovf) begin
                r2_item.bypass <= 1'b1;
                r2_item.sat    <= 1'b1;
                r2_item.quo    <= psc_pkg::PSC_ALL_ONES;
            end else begin
                r2_item.bypass <= 1'b0;
                r2_item.sat    <= 1'b0;
                r2_item.quo    <= n_prod[VW-1:0];
            end
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r2_item;

endmodule

/* rtl/psc_div_stage.sv */
module psc_div_stage #(
    parameter int DIV_BITS = psc_pkg::PSC_DIV_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  psc_pkg::t_div_item i_item,
    output logic               o_valid,
    output psc_pkg::t_div_item o_item
);

    localparam int RW = psc_pkg::PSC_REM_W;
    localparam int VW = psc_pkg::PSC_VALUE_W;

    logic               r_valid;
    psc_pkg::t_div_item r_item;
    psc_pkg::t_div_item n_item;

    // restoring long division, remainder kept below the divisor
    always_comb begin
        logic [RW:0] trial;
        trial  = '0;
        n_item = i_item;
        if (!i_item.bypass) begin
            for (int s = 0; s < DIV_BITS; s++) begin
                trial = {n_item.rem, n_item.quo[VW-1]};
                if (trial >= {1'b0, i_item.divisor}) begin
                    trial = trial - {1'b0, i_item.divisor};
                    n_item.quo = {n_item.quo[VW-2:0], 1'b1};
                end else begin
                    n_item.quo = {n_item.quo[VW-2:0], 1'b0};
                end
                n_item.rem = trial[RW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && i_valid) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

/* rtl/probability_scale_saturating.sv */
// Scales a 64-bit unsigned value by a 32-bit fraction: scaled = floor(value * num / den),
// or value * den / num when func is set. A zero value or equal terms pass the value
// through; a zero divisor or a quotient wider than 64 bits gives all ones with saturated
// set. The block is a pipeline of 3 + 64/DIV_BITS register stages (19 with the default
// of 4 quotient bits per stage): operand select, two 32x32 partial products, product
// assembly with the overflow test, then the long division a few quotient bits per stage.
// One item is accepted every cycle unless a stall at the output has backed up to the
// input. A stalled output holds its item while empty stages further up keep filling.
module probability_scale_saturating #(
    parameter int DIV_BITS = psc_pkg::PSC_DIV_BITS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    psc_in_if.sink           i_in,
    psc_out_if.source        o_out
);

    localparam int NDIV   = psc_pkg::PSC_VALUE_W / DIV_BITS;
    localparam int NSTAGE = 3 + NDIV;

    logic [NSTAGE-1:0]  en;
    logic [NSTAGE-1:0]  valid;
    logic [2:0]         front_valid;
    psc_pkg::t_div_item item [NDIV+1];

    // a stage moves when it is empty or the one after it moves
    always_comb begin
        en[NSTAGE-1] = !valid[NSTAGE-1] || o_out.ready;
        for (int k = NSTAGE - 2; k >= 0; k--) begin
            en[k] = !valid[k] || en[k+1];
        end
    end

    psc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en[2:0]),
        .i_valid (i_in.valid),
        .i_func  (i_in.func),
        .i_value (i_in.value),
        .i_num   (i_in.prob_numerator),
        .i_den   (i_in.prob_denominator),
        .o_valid (front_valid),
        .o_item  (item[0])
    );

    assign valid[2:0] = front_valid;

    for (genvar g = 0; g < NDIV; g++) begin : g_div
        psc_div_stage #(
            .DIV_BITS (DIV_BITS)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en[3+g]),
            .i_valid (valid[2+g]),
            .i_item  (item[g]),
            .o_valid (valid[3+g]),
            .o_item  (item[g+1])
        );
    end

    assign i_in.ready      = en[0];
    assign o_out.valid     = valid[NSTAGE-1];
    assign o_out.scaled    = item[NDIV].quo;
    assign o_out.saturated = item[NDIV].sat;

endmodule

/* rtl/psc_checker.sv */
module psc_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_ready,
    input logic                            i_out_valid,
    input logic                            i_out_ready,
    input logic [psc_pkg::PSC_VALUE_W-1:0] i_out_scaled,
    input logic                            i_out_saturated
);

    // a stalled result item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_scaled) && $stable(i_out_saturated))
        else $error("result item changed while stalled");

    // saturation always reports all ones
    a_sat_ones: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_saturated |-> i_out_scaled == psc_pkg::PSC_ALL_ONES)
        else $error("saturated item without all ones");

    // a free output end never blocks the input
    a_in_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid || i_out_ready |-> i_in_ready)
        else $error("input stalled with output free");

    // nothing comes out right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !i_out_valid)
        else $error("result item straight after reset");

endmodule

bind probability_scale_saturating psc_checker u_psc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_out_scaled    (o_out.scaled),
    .i_out_saturated (o_out.saturated)
);

/* sim/tb_probability_scale_saturating.sv */
module tb_probability_scale_saturating;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        psc_pkg::t_func                  func;
        logic [psc_pkg::PSC_VALUE_W-1:0] value;
        logic [psc_pkg::PSC_TERM_W-1:0]  num;
        logic [psc_pkg::PSC_TERM_W-1:0]  den;
    } t_scale_req;

    typedef struct packed {
        logic [psc_pkg::PSC_VALUE_W-1:0] scaled;
        logic                            saturated;
    } t_scale_res;

    typedef enum int {
        MIX_FULL,
        MIX_SHRINK,
        MIX_EQUAL,
        MIX_ZERO_TERM,
        MIX_NARROW_VALUE,
        MIX_EDGE
    } t_mix;

    typedef enum int {
        RX_FREE,
        RX_MOSTLY,
        RX_SPARSE,
        RX_PATTERN
    } t_rx_mode;

    localparam int N_RANDOM      = 1050;
    localparam int HOLD_OFF_AT   = 300;
    localparam int HOLD_OFF_LEN  = 250;
    localparam int SECOND_PAUSE  = 700;
    localparam int TAIL_CYCLES   = 60;
    localparam int MAX_REPORTS   = 40;

    logic i_clk;
    logic i_rst_n;

    psc_in_if  in_if();
    psc_out_if out_if();

    probability_scale_saturating uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    t_scale_req pending_reqs[$];
    t_scale_res due_results[$];
    t_scale_req cur_req;

    bit holding;
    bit in_took;
    bit draining;
    int issued;
    int n_directed;
    int burst_left;
    int gap_left;

    int hold_off_left;
    bit hold_off_done;
    t_rx_mode rx_mode;
    int rx_mode_left;
    int rx_pattern_cnt;

    int results_seen;
    int sat_seen;
    int in_stall_cycles;
    int errors;

    initial i_clk = 1'b0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic t_scale_res predict_scale(t_scale_req r);
        logic [psc_pkg::PSC_TERM_W-1:0] mul;
        logic [psc_pkg::PSC_TERM_W-1:0] dvs;
        logic [95:0]                    product;
        logic [95:0]                    quot;
        t_scale_res                     res;
        mul = (r.func == psc_pkg::PSC_FUNC_DEN_OVER_NUM) ? r.den : r.num;
        dvs = (r.func == psc_pkg::PSC_FUNC_DEN_OVER_NUM) ? r.num : r.den;
        res.scaled    = r.value;
        res.saturated = 1'b0;
        if (r.value == '0 || mul == dvs)
            return res;
        if (dvs == '0) begin
            res.scaled    = psc_pkg::PSC_ALL_ONES;
            res.saturated = 1'b1;
            return res;
        end
        product = {32'd0, r.value} * {64'd0, mul};
        quot    = product / {64'd0, dvs};
        if (quot[95:64] != '0) begin
            res.scaled    = psc_pkg::PSC_ALL_ONES;
            res.saturated = 1'b1;
        end else begin
            res.scaled = quot[63:0];
        end
        return res;
    endfunction

    // mul and dvs are the roles in the product; func decides which port carries which
    task automatic add_scale(psc_pkg::t_func f, logic [psc_pkg::PSC_VALUE_W-1:0] v,
                             logic [psc_pkg::PSC_TERM_W-1:0] mul,
                             logic [psc_pkg::PSC_TERM_W-1:0] dvs);
        t_scale_req r;
        r.func  = f;
        r.value = v;
        r.num   = (f == psc_pkg::PSC_FUNC_DEN_OVER_NUM) ? dvs : mul;
        r.den   = (f == psc_pkg::PSC_FUNC_DEN_OVER_NUM) ? mul : dvs;
        pending_reqs.push_back(r);
    endtask

    // sender: bursts and gaps, with pauses until the pipeline has drained
    always @(negedge i_clk) begin : tx_drive
        if (in_took)
            holding = 1'b0;
        if (i_rst_n && !holding) begin
            if (draining) begin
                if (due_results.size() == 0)
                    draining = 1'b0;
            end else if (gap_left > 0) begin
                gap_left--;
            end else if (pending_reqs.size() > 0) begin
                cur_req = pending_reqs.pop_front();
                holding = 1'b1;
                issued++;
                if (issued == n_directed || issued == n_directed + SECOND_PAUSE)
                    draining = 1'b1;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left--;
                end
            end
        end
        in_if.valid            <= holding;
        in_if.func             <= cur_req.func;
        in_if.value            <= cur_req.value;
        in_if.prob_numerator   <= cur_req.num;
        in_if.prob_denominator <= cur_req.den;
    end

    // receiver: changing stall modes plus one long hold-off
    always @(negedge i_clk) begin : rx_stall
        logic rdy;
        if (hold_off_left > 0) begin
            hold_off_left--;
            rdy = 1'b0;
        end else if (!hold_off_done && results_seen >= HOLD_OFF_AT) begin
            hold_off_done = 1'b1;
            hold_off_left = HOLD_OFF_LEN - 1;
            rdy = 1'b0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode      = t_rx_mode'($urandom_range(0, 3));
                rx_mode_left = $urandom_range(20, 120);
            end
            rx_mode_left--;
            case (rx_mode)
                RX_FREE:   rdy = 1'b1;
                RX_MOSTLY: rdy = ($urandom_range(0, 99) < 75);
                RX_SPARSE: rdy = ($urandom_range(0, 99) < 30);
                default: begin
                    rdy = ((rx_pattern_cnt % 7) < 4);
                    rx_pattern_cnt++;
                end
            endcase
        end
        out_if.ready <= rdy;
    end

    always @(posedge i_clk) begin : watch
        t_scale_res want;
        in_took = 1'b0;
        if (i_rst_n) begin
            if (out_if.valid && out_if.ready) begin
                results_seen++;
                if (due_results.size() == 0) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: unexpected item scaled=%h saturated=%b", $time,
                                 out_if.scaled, out_if.saturated);
                end else begin
                    want = due_results.pop_front();
                    if (want.saturated)
                        sat_seen++;
                    if (out_if.scaled !== want.scaled) begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                            $display("%0t: scaled expected %h actual %h", $time,
                                     want.scaled, out_if.scaled);
                    end
                    if (out_if.saturated !== want.saturated) begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                            $display("%0t: saturated expected %b actual %b", $time,
                                     want.saturated, out_if.saturated);
                    end
                end
            end
            if (in_if.valid && in_if.ready) begin
                due_results.push_back(predict_scale(cur_req));
                in_took = 1'b1;
            end
            if (in_if.valid && !in_if.ready)
                in_stall_cycles++;
        end
    end

    initial begin : stimulus
        psc_pkg::t_func                  f;
        t_mix                            mix;
        logic [psc_pkg::PSC_VALUE_W-1:0] v;
        logic [psc_pkg::PSC_TERM_W-1:0]  mul;
        logic [psc_pkg::PSC_TERM_W-1:0]  dvs;
        logic [127:0]                    span;

        i_rst_n                = 1'b0;
        in_if.valid            = 1'b0;
        in_if.func             = 1'b0;
        in_if.value            = '0;
        in_if.prob_numerator   = '0;
        in_if.prob_denominator = '0;
        out_if.ready           = 1'b0;
        cur_req                = '0;

        // zero value and equal terms pass through
        add_scale(psc_pkg::PSC_FUNC_NUM_OVER_DEN, 64'd0, 32'd5, 32'd3);
        add_scale(psc_pkg::PSC_FUNC_NUM_OVER_DEN, 64'd0, 32'd7, 32'd0);
        add_scale(psc_pkg::PSC_FUNC_DEN_OVER_NUM, 64'h0123_4567_89AB_CDEF, 32'd0, 32'd0);
        add_scale(psc_pkg::PSC_FUNC_NUM_OVER_DEN, psc_pkg::PSC_ALL_ONES,
                  32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // zero divisor
        add_scale(psc_pkg::PSC_FUNC_NUM_OVER_DEN, 64'd1, 32'd1, 32'd0);
        add_scale(psc_pkg::PSC_FUNC_DEN_OVER_NUM, 64'd12345, 32'd9, 32'd0);
        // extremes of value and terms
        add_scale(psc_pkg::PSC_FUNC_NUM_OVER_DEN, psc_pkg::PSC_ALL_ONES, 32'd1, 32'hFFFF_FFFF);
        add_scale(psc_pkg::PSC_FUNC_NUM_OVER_DEN, psc_pkg::PSC_ALL_ONES, 32'hFFFF_FFFF, 32'd1);
        add_scale(psc_pkg::PSC_FUNC_NUM_OVER_DEN, psc_pkg::PSC_ALL_ONES, 32'd1, 32'd2);
        add_scale(psc_pkg::PSC_FUNC_DEN_OVER_NUM, psc_pkg::PSC_ALL_ONES, 32'd1, 32'd2);
        // quotient exactly all ones, then one past it
        add_scale(psc_pkg::PSC_FUNC_NUM_OVER_DEN, 64'h9999_9999_9999_9999, 32'd5, 32'd3);
        add_scale(psc_pkg::PSC_FUNC_DEN_OVER_NUM, 64'h9999_9999_9999_9999, 32'd5, 32'd3);
        add_scale(psc_pkg::PSC_FUNC_NUM_OVER_DEN, 64'h9999_9999_9999_999A, 32'd5, 32'd3);
        add_scale(psc_pkg::PSC_FUNC_NUM_OVER_DEN, 64'd1, 32'hFFFF_FFFF, 32'd1);
        add_scale(psc_pkg::PSC_FUNC_NUM_OVER_DEN, 64'h1_0000_0000, 32'hFFFF_FFFF, 32'd1);
        add_scale(psc_pkg::PSC_FUNC_DEN_OVER_NUM, psc_pkg::PSC_ALL_ONES, 32'd0, 32'd1);
        add_scale(psc_pkg::PSC_FUNC_NUM_OVER_DEN, 64'h8000_0000_0000_0000, 32'd2, 32'd1);
        add_scale(psc_pkg::PSC_FUNC_NUM_OVER_DEN, 64'h7FFF_FFFF_FFFF_FFFF, 32'd2, 32'd1);
        add_scale(psc_pkg::PSC_FUNC_NUM_OVER_DEN, {$urandom, $urandom},
                  32'hFFFF_FFFF, 32'hFFFF_FFFE);
        add_scale(psc_pkg::PSC_FUNC_DEN_OVER_NUM, 64'hDEAD_BEEF_0BAD_F00D, 32'd3, 32'd7);
        n_directed = pending_reqs.size();

        for (int i = 0; i < N_RANDOM; i++) begin
            f   = psc_pkg::t_func'($urandom_range(0, 1));
            v   = {$urandom, $urandom};
            mul = $urandom;
            dvs = $urandom;
            mix = t_mix'($urandom_range(0, 5));
            case (mix)
                MIX_SHRINK: mul = $urandom_range(0, dvs);
                MIX_EQUAL: mul = dvs;
                MIX_ZERO_TERM: begin
                    case ($urandom_range(0, 2))
                        0:       mul = '0;
                        1:       dvs = '0;
                        default: begin
                            mul = '0;
                            dvs = '0;
                        end
                    endcase
                end
                MIX_NARROW_VALUE: begin
                    v = v >> $urandom_range(0, 63);
                    if ($urandom_range(0, 1) == 1) begin
                        mul = mul >> $urandom_range(0, 31);
                        dvs = dvs >> $urandom_range(0, 31);
                    end
                end
                MIX_EDGE: begin
                    // value on either side of the 64-bit overflow boundary
                    dvs  = ($urandom_range(0, 1) == 1) ? $urandom_range(1, 16)
                                                       : $urandom_range(1, 32'hFFFF_FFFE);
                    mul  = $urandom_range(dvs + 1, 32'hFFFF_FFFF);
                    span = ({96'd0, dvs} << 64) / {96'd0, mul};
                    v    = span[63:0] + 64'($urandom_range(0, 2)) - 64'd1;
                end
                default: ;
            endcase
            add_scale(f, v, mul, dvs);
        end

        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || holding)
            @(posedge i_clk);
        while (due_results.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d items (%0d directed), %0d results, %0d saturated",
                 issued, n_directed, results_seen, sat_seen);
        $display("input stalled on %0d cycles, receiver hold-off of %0d cycles done: %0b",
                 in_stall_cycles, HOLD_OFF_LEN, hold_off_done);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("timeout with %0d items still expected", due_results.size());
        $display("Regression FAIL");
        $finish;
    end

endmodule
